@@ hw/rtl/evd_pkg.sv @@
// ----------------------------------------------------------------------------
// evd_pkg: shared types and constants of the escaped value decoder
// Byte classes, result word layout, character codes and helper functions.
// ----------------------------------------------------------------------------
package evd_pkg;

    localparam int EVD_MAX_LENGTH  = 2048;
    localparam int EVD_QUEUE_DEPTH = 4;
    localparam int EVD_SPACE_W     = 12;

    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_X      = 8'h78;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_SEVEN  = 8'h37;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TILDE  = 8'h7E;

    // Classified input byte, as the front hands it to the back.
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] named;
        logic [3:0] hex_val;
        logic       is_zero;
        logic       is_quote;
        logic       is_bslash;
        logic       is_x;
        logic       is_oct;
        logic       is_hex;
        logic       is_print;
        logic       is_space;
    } t_cls;

    // One result word.
    typedef struct packed {
        logic [7:0]             out_byte;
        logic [EVD_SPACE_W-1:0] spaces_before;
        logic                   byte_valid;
        logic                   value_end;
        logic                   unterminated;
    } t_res;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] named_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h6E: r = 8'h0A;   // n
            8'h72: r = 8'h0D;   // r
            8'h62: r = 8'h08;   // b
            8'h76: r = 8'h0B;   // v
            8'h61: r = 8'h07;   // a
            8'h66: r = 8'h0C;   // f
            8'h74: r = 8'h09;   // t
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/escaped_value_decoder_top.sv @@
// ----------------------------------------------------------------------------
// escaped_value_decoder_top: escaped settings value decoder
// Decodes C-escaped quoted or unquoted values, a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Push the raw bytes of a value, closed by a zero byte; pop decoded words.
// The first byte picks the mode: a double quote starts a quoted value with
// C escapes (named, \x with up to two hex digits, octal with up to three),
// any other printable byte starts an unquoted value that copies printable
// bytes and carries each run of spaces as spaces_before on the next copied
// byte. Every value closes with exactly one end word (value_end = 1), which
// flags unterminated when a quoted value lacks its closing quote. Input and
// output are both queues: push is taken while full is low, and the oldest
// word sits on the output ports while empty is low. A byte is taken every
// cycle while full is low; the back engine writes at most one word per
// cycle into the output queue, none while it is full, so a byte that breaks
// off a hex or octal escape is taken twice: once for the escape's word, then
// again in the quoted text. A byte waits in the classified-byte queue until
// the engine takes it, its word in the output queue until popped. Both
// queues hold EVD_QUEUE_DEPTH words, so either side may stall without the
// other. The space count saturates at the smaller of P_MAX_LENGTH and 4095.
// ----------------------------------------------------------------------------
module escaped_value_decoder_top #(
    parameter int P_MAX_LENGTH = evd_pkg::EVD_MAX_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [11:0] o_spaces_before,
    output logic        o_byte_valid,
    output logic        o_value_end,
    output logic        o_unterminated
);
    import evd_pkg::*;

    t_cls cls_in, cls_q;
    t_res res_new, res_q;
    logic mid_empty, mid_pop;
    logic res_full, res_push;

    // Front: classify the byte on the way in.
    evd_front u_front (
        .i_byte (i_in_byte),
        .o_cls  (cls_in)
    );

    // Hold classified bytes until the engine takes them.
    evd_fifo #(
        .P_WIDTH ($bits(t_cls)),
        .P_DEPTH (EVD_QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (cls_q),
        .o_empty (mid_empty)
    );

    // Back: advance decode state, drop or emit one word per cycle unless res_full or no byte waits.
    evd_back #(
        .P_MAX_LENGTH (P_MAX_LENGTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!mid_empty),
        .i_item       (cls_q),
        .o_item_pop   (mid_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_new)
    );

    // Hold finished words for the consumer.
    evd_fifo #(
        .P_WIDTH ($bits(t_res)),
        .P_DEPTH (EVD_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_new),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_out_byte      = res_q.out_byte;
    assign o_spaces_before = res_q.spaces_before;
    assign o_byte_valid    = res_q.byte_valid;
    assign o_value_end     = res_q.value_end;
    assign o_unterminated  = res_q.unterminated;

endmodule

@@ hw/rtl/evd_fifo.sv @@
// ----------------------------------------------------------------------------
// evd_fifo: small register queue
// Generic first-in first-out queue with registered storage and a count.
// ----------------------------------------------------------------------------
module evd_fifo #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic [P_WIDTH-1:0] o_data,
    output logic               o_empty
);
    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]      r_wr, r_rd;
    logic [CW-1:0]      r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/evd_front.sv @@
// ----------------------------------------------------------------------------
// evd_front: input byte classifier
// Tags each accepted byte with the character classes the decoder needs.
// ----------------------------------------------------------------------------
module evd_front (
    input  logic          [7:0] i_byte,
    output evd_pkg::t_cls       o_cls
);
    import evd_pkg::*;

    logic [4:0] hex;

    assign hex = hex_decode(i_byte);

    always_comb begin
        o_cls.ch        = i_byte;
        o_cls.named     = named_escape(i_byte);
        o_cls.hex_val   = hex[3:0];
        o_cls.is_hex    = hex[4];
        o_cls.is_zero   = (i_byte == 8'h00);
        o_cls.is_quote  = (i_byte == C_QUOTE);
        o_cls.is_bslash = (i_byte == C_BSLASH);
        o_cls.is_x      = (i_byte == C_X);
        o_cls.is_oct    = (i_byte >= C_ZERO) && (i_byte <= C_SEVEN);
        o_cls.is_print  = (i_byte >= C_SPACE) && (i_byte <= C_TILDE);
        o_cls.is_space  = (i_byte == C_SPACE);
    end

endmodule

@@ hw/rtl/evd_back.sv @@
// ----------------------------------------------------------------------------
// evd_back: decode engine
// Runs the mode and escape state machines and writes at most one result per cycle, none while i_res_full.
// ----------------------------------------------------------------------------
module evd_back #(
    parameter int P_MAX_LENGTH = evd_pkg::EVD_MAX_LENGTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    input  evd_pkg::t_cls i_item,
    output logic          o_item_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output evd_pkg::t_res o_res
);
    import evd_pkg::*;

    localparam int SPACE_CAP_I = (P_MAX_LENGTH < 4095) ? P_MAX_LENGTH : 4095;
    localparam logic [EVD_SPACE_W-1:0] SPACE_CAP = EVD_SPACE_W'(SPACE_CAP_I);

    typedef enum logic [3:0] {
        MODE_START    = 4'b0001,
        MODE_QUOTED   = 4'b0010,
        MODE_UNQUOTED = 4'b0100,
        MODE_DONE     = 4'b1000
    } t_mode;

    typedef enum logic [5:0] {
        PH_NONE   = 6'b000001,
        PH_BSLASH = 6'b000010,
        PH_HEX0   = 6'b000100,
        PH_HEX1   = 6'b001000,
        PH_OCT1   = 6'b010000,
        PH_OCT2   = 6'b100000
    } t_phase;

    t_mode                  r_mode, n_mode;
    t_phase                 r_phase, n_phase;
    logic [8:0]             r_val, n_val;
    logic [EVD_SPACE_W-1:0] r_pend, n_pend;
    logic                   go, emit, retry;
    t_cls                   c;

    assign c  = i_item;
    assign go = i_item_valid && !i_res_full;

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_val   = r_val;
        n_pend  = r_pend;
        o_res   = '0;
        emit    = 1'b0;
        retry   = 1'b0;
        if (go) begin
            case (r_mode)
                MODE_START: begin
                    if (c.is_zero) begin
                        emit = 1'b1;
                        o_res.value_end = 1'b1;
                    end else if (c.is_quote) begin
                        n_mode  = MODE_QUOTED;
                        n_phase = PH_NONE;
                        n_val   = '0;
                    end else if (!c.is_print) begin
                        n_mode = MODE_DONE;
                        n_pend = '0;
                    end else if (c.is_space) begin
                        n_mode = MODE_UNQUOTED;
                        n_pend = EVD_SPACE_W'(1);
                    end else begin
                        n_mode = MODE_UNQUOTED;
                        n_pend = '0;
                        emit   = 1'b1;
                        o_res.out_byte   = c.ch;
                        o_res.byte_valid = 1'b1;
                    end
                end
                MODE_UNQUOTED: begin
                    if (c.is_zero) begin
                        emit = 1'b1;
                        o_res.value_end = 1'b1;
                        n_mode = MODE_START;
                        n_pend = '0;
                    end else if (!c.is_print) begin
                        n_mode = MODE_DONE;
                        n_pend = '0;
                    end else if (c.is_space) begin
                        if (r_pend < SPACE_CAP) begin
                            n_pend = r_pend + 1'b1;
                        end
                    end else begin
                        emit = 1'b1;
                        o_res.out_byte      = c.ch;
                        o_res.spaces_before = r_pend;
                        o_res.byte_valid    = 1'b1;
                        n_pend = '0;
                    end
                end
                MODE_QUOTED: begin
                    case (r_phase)
                        PH_BSLASH: begin
                            if (c.is_zero) begin
                                emit = 1'b1;
                                o_res.value_end    = 1'b1;
                                o_res.unterminated = 1'b1;
                                n_mode  = MODE_START;
                                n_phase = PH_NONE;
                                n_val   = '0;
                            end else if (c.is_x) begin
                                n_phase = PH_HEX0;
                                n_val   = '0;
                            end else if (c.is_oct) begin
                                n_phase = PH_OCT1;
                                n_val   = {6'b0, c.ch[2:0]};
                            end else begin
                                n_phase = PH_NONE;
                                emit = 1'b1;
                                o_res.out_byte   = c.named;
                                o_res.byte_valid = 1'b1;
                            end
                        end
                        PH_HEX0: begin
                            if (c.is_hex) begin
                                n_phase = PH_HEX1;
                                n_val   = {5'b0, c.hex_val};
                            end else begin
                                // emit the lone x, then replay this byte
                                n_phase = PH_NONE;
                                retry   = 1'b1;
                                emit    = 1'b1;
                                o_res.out_byte   = C_X;
                                o_res.byte_valid = 1'b1;
                            end
                        end
                        PH_HEX1: begin
                            n_phase = PH_NONE;
                            emit    = 1'b1;
                            o_res.byte_valid = 1'b1;
                            if (c.is_hex) begin
                                o_res.out_byte = {r_val[3:0], c.hex_val};
                            end else begin
                                retry = 1'b1;
                                o_res.out_byte = r_val[7:0];
                            end
                        end
                        PH_OCT1: begin
                            if (c.is_oct) begin
                                n_phase = PH_OCT2;
                                n_val   = {r_val[5:0], c.ch[2:0]};
                            end else begin
                                n_phase = PH_NONE;
                                retry   = 1'b1;
                                emit    = 1'b1;
                                o_res.out_byte   = r_val[7:0];
                                o_res.byte_valid = 1'b1;
                            end
                        end
                        PH_OCT2: begin
                            n_phase = PH_NONE;
                            emit    = 1'b1;
                            o_res.byte_valid = 1'b1;
                            if (c.is_oct) begin
                                o_res.out_byte = {r_val[4:0], c.ch[2:0]};
                            end else begin
                                retry = 1'b1;
                                o_res.out_byte = r_val[7:0];
                            end
                        end
                        default: begin
                            n_phase = PH_NONE;
                            if (c.is_zero) begin
                                emit = 1'b1;
                                o_res.value_end    = 1'b1;
                                o_res.unterminated = 1'b1;
                                n_mode = MODE_START;
                                n_val  = '0;
                            end else if (c.is_bslash) begin
                                n_phase = PH_BSLASH;
                                n_val   = '0;
                            end else if (c.is_quote) begin
                                n_mode = MODE_DONE;
                            end else begin
                                emit = 1'b1;
                                o_res.out_byte   = c.ch;
                                o_res.byte_valid = 1'b1;
                            end
                        end
                    endcase
                end
                default: begin
                    if (c.is_zero) begin
                        emit = 1'b1;
                        o_res.value_end = 1'b1;
                        n_mode  = MODE_START;
                        n_phase = PH_NONE;
                        n_val   = '0;
                        n_pend  = '0;
                    end
                end
            endcase
        end
    end

    assign o_item_pop = go && !retry;
    assign o_res_push = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_START;
            r_phase <= PH_NONE;
            r_val   <= '0;
            r_pend  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_val   <= n_val;
            r_pend  <= n_pend;
        end
    end

endmodule
